### design/bsa_pkg.sv
// Shared types, constants and helper functions of the record slot allocator.
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int unsigned BLK_W      = 8;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned WIDX_W     = 4;
    localparam int unsigned MAP_WORDS  = 16;
    localparam int unsigned MAP_DEPTH  = 4096;
    localparam int unsigned NUM_BLOCKS = 256;
    localparam int unsigned SIZE_W     = 13;
    localparam int unsigned SLOT_W     = 10;
    localparam int unsigned CNT_W      = 11;
    localparam int unsigned ADDR_W     = 21;
    localparam int unsigned PROD_W     = 23;

    localparam logic [BLK_W-1:0]  META_BLK   = 8'd8;
    localparam logic [BLK_W-1:0]  FIRST_BLK  = 8'd9;
    localparam logic [BLK_W-1:0]  LAST_BLK   = 8'd255;
    localparam logic [SIZE_W-1:0] HDR_BYTES  = 13'd136;
    localparam logic [SIZE_W-1:0] PAYLOAD    = 13'd8056;
    localparam logic [SIZE_W-1:0] RESET_SIZE = 13'd64;
    localparam logic [CNT_W-1:0]  SLOT_MAX   = 11'd1024;
    localparam logic [CNT_W-1:0]  RESET_R    = 11'd125;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_RESERVED = 2'd0,
        ST_UNUSED   = 2'd1,
        ST_PARTIAL  = 2'd2,
        ST_FULL     = 2'd3
    } t_blk_st;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_EXHAUSTED = 2'd1,
        ERR_BAD_FREE  = 2'd2
    } t_err;

    // bits of map word w that hold real slots (index below r)
    function automatic logic [WORD_W-1:0] word_mask(input logic [CNT_W-1:0] r,
                                                    input logic [WIDX_W-1:0] w);
        logic [CNT_W-1:0] base;
        logic [CNT_W-1:0] span;
        base = {1'b0, w, 6'b0};
        span = r - base;
        if (r >= base + CNT_W'(WORD_W)) begin
            word_mask = '1;
        end else if (r <= base) begin
            word_mask = '0;
        end else begin
            word_mask = (WORD_W'(1) << span[5:0]) - WORD_W'(1);
        end
    endfunction

    // index of the lowest set bit
    function automatic logic [5:0] low_bit(input logic [WORD_W-1:0] v);
        low_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                low_bit = 6'(i);
            end
        end
    endfunction

    function automatic t_blk_st blk_default(input logic [BLK_W-1:0] b);
        blk_default = (b < META_BLK) ? ST_RESERVED : ST_UNUSED;
    endfunction

endpackage

### design/bsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps

module bsa_ram #(
    parameter int unsigned W = 64,
    parameter int unsigned D = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### design/bsa_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bsa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bsa_pkg::SIZE_W-1:0] i_dividend,
    input  logic [bsa_pkg::SIZE_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [bsa_pkg::SIZE_W-1:0] o_quo,
    output logic [bsa_pkg::SIZE_W-1:0] o_rem
);
    import bsa_pkg::*;

    localparam logic [3:0] LAST_STEP = 4'(SIZE_W - 1);

    logic              r_busy;
    logic [3:0]        r_cnt;
    logic [SIZE_W-1:0] r_q;
    logic [SIZE_W-1:0] r_r;
    logic [SIZE_W-1:0] r_d;
    logic [SIZE_W:0]   sh;
    logic              ge;

    assign sh = {r_r, r_q[SIZE_W-1]};
    assign ge = sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                r_r   <= ge ? SIZE_W'(sh - {1'b0, r_d}) : sh[SIZE_W-1:0];
                r_q   <= {r_q[SIZE_W-2:0], ge};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_q;
    assign o_rem = r_r;

endmodule

### design/bitmap_record_slot_allocator.sv
// Top level: slot bitmap allocator with its sequencer, bitmap and status memories.
`timescale 1ns / 1ps

// Hands out and takes back fixed-size records in 8 KiB blocks.
// Input channel (i_in_valid / o_in_stall) carries an opcode (0 allocate, 1 free)
// and a byte address for free. Output channel (o_out_valid / i_out_stall) gives
// one result word per input word: address, slot, block, block status, error.
// Record size is written through i_cfg_we / i_cfg_wdata; the user must do so only
// while the block is idle, which the block itself does not enforce. One word is
// worked on at a time; o_in_stall is high until its result is loaded into the
// output register, so the next word can enter while a result waits. Allocate:
// a 16-word scan of the block bitmap memory (one 64-bit word per cycle), then,
// when the block fills, the bitmap of the next block is written. Free: the
// record-size divider plus the read-modify-write and emptiness scan of the bitmap.
// After a record size write, the first word waits for the divider to recompute
// slots per block. Reset: a pass writes the bitmap of the first data block with
// the input stalled. A stalled output holds its word; the sequencer waits for it.
module bitmap_record_slot_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_opcode,
    input  logic [bsa_pkg::ADDR_W-1:0] i_free_address,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [bsa_pkg::ADDR_W-1:0] o_granted_address,
    output logic [bsa_pkg::SLOT_W-1:0] o_slot_index,
    output logic [bsa_pkg::BLK_W-1:0]  o_block_number,
    output logic [1:0]                 o_block_state,
    output logic [1:0]                 o_error_code,
    input  logic                       i_cfg_we,
    input  logic [bsa_pkg::SIZE_W-1:0] i_cfg_wdata
);
    import bsa_pkg::*;

    typedef enum logic [15:0] {
        S_INIT  = 16'h0001,
        S_IDLE  = 16'h0002,
        S_DEC   = 16'h0004,
        S_DIVR  = 16'h0008,
        S_BR    = 16'h0010,
        S_ASCAN = 16'h0020,
        S_AEND  = 16'h0040,
        S_AINIT = 16'h0080,
        S_ADDR  = 16'h0100,
        S_FDIV  = 16'h0200,
        S_FRD0  = 16'h0400,
        S_FRD1  = 16'h0800,
        S_FWR   = 16'h1000,
        S_FSCAN = 16'h2000,
        S_FEND  = 16'h4000,
        S_OUT   = 16'h8000
    } t_state;

    t_state             r_state;
    logic [SIZE_W-1:0]  r_rec_size;
    logic [CNT_W-1:0]   r_slots;
    logic               r_slots_ok;
    logic [BLK_W-1:0]   r_cur;
    logic               r_exh;
    logic [NUM_BLOCKS-1:0] r_stv;
    t_op                r_op;
    logic [ADDR_W-1:0]  r_addr;
    logic [BLK_W-1:0]   r_blk;
    logic [SLOT_W-1:0]  r_slot;
    logic [WIDX_W-1:0]  r_wi;
    logic [WORD_W-1:0]  r_word;
    logic [WIDX_W:0]    r_cnt;
    logic               r_dv;
    logic [WIDX_W-1:0]  r_dw;
    logic               r_found;
    logic               r_more;
    t_blk_st            r_st;
    t_err               r_err;
    logic [ADDR_W-1:0]  r_gaddr;
    logic [PROD_W-1:0]  r_prod;

    logic [SIZE_W-1:0]  eff;
    logic [SIZE_W-1:0]  off;
    logic               map_we;
    logic [11:0]        map_waddr;
    logic [11:0]        map_raddr;
    logic [WORD_W-1:0]  map_wdata;
    logic [WORD_W-1:0]  map_rdata;
    logic               st_we;
    t_blk_st            st_wdata;
    logic [1:0]         st_rdata;
    t_blk_st            st_cur;
    logic [WORD_W-1:0]  sc_mask;
    logic [WORD_W-1:0]  sc_free;
    logic [WORD_W-1:0]  sc_used;
    logic [5:0]         sc_bit;
    logic               div_start;
    logic [SIZE_W-1:0]  div_dividend;
    logic               div_done;
    logic [SIZE_W-1:0]  div_quo;
    logic [SIZE_W-1:0]  div_rem;
    logic               out_load;
    t_blk_st            alloc_st;
    logic               free_ok;

    assign eff      = (r_rec_size == '0) ? SIZE_W'(1) : r_rec_size;
    assign off      = r_addr[SIZE_W-1:0];
    assign st_cur   = r_stv[r_blk] ? t_blk_st'(st_rdata) : blk_default(r_blk);
    assign sc_mask  = word_mask(r_slots, r_dw);
    assign sc_free  = ~map_rdata & sc_mask;
    assign sc_used  = map_rdata & sc_mask;
    assign sc_bit   = low_bit(sc_free);
    assign out_load = !o_out_valid || !i_out_stall;
    assign alloc_st = !r_more ? ST_FULL : ((r_st == ST_UNUSED) ? ST_PARTIAL : r_st);
    assign free_ok  = (r_addr[ADDR_W-1:SIZE_W] > META_BLK)
                   && (r_addr[ADDR_W-1:SIZE_W] <= r_cur) && (off >= HDR_BYTES);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        map_we    = 1'b0;
        map_waddr = {r_cur, r_cnt[WIDX_W-1:0]};
        map_wdata = ~word_mask(r_slots, r_cnt[WIDX_W-1:0]);
        map_raddr = {r_blk, r_cnt[WIDX_W-1:0]};
        st_we     = 1'b0;
        st_wdata  = alloc_st;
        unique case (r_state)
            S_INIT, S_AINIT: begin
                map_we = 1'b1;
            end
            S_AEND: begin
                map_we    = r_found;
                map_waddr = {r_blk, r_wi};
                map_wdata = r_word;
                st_we     = r_found;
            end
            S_FRD0: begin
                map_raddr = {r_blk, r_slot[SLOT_W-1:6]};
            end
            S_FWR: begin
                map_we    = 1'b1;
                map_waddr = {r_blk, r_slot[SLOT_W-1:6]};
                map_wdata = r_word;
            end
            S_FEND: begin
                st_we    = !r_more;
                st_wdata = ST_UNUSED;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = PAYLOAD;
        if (r_state == S_DEC && !r_slots_ok) begin
            div_start = 1'b1;
        end else if (r_state == S_BR && r_op == OP_FREE && free_ok) begin
            div_start    = 1'b1;
            div_dividend = off - HDR_BYTES;
        end
    end

    bsa_ram #(.W(WORD_W), .D(MAP_DEPTH)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    bsa_ram #(.W(2), .D(NUM_BLOCKS)) u_status (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_blk),
        .i_wdata (st_wdata),
        .i_raddr (r_blk),
        .o_rdata (st_rdata)
    );

    bsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (eff),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_rec_size  <= RESET_SIZE;
            r_slots     <= RESET_R;
            r_slots_ok  <= 1'b1;
            r_cur       <= FIRST_BLK;
            r_exh       <= 1'b0;
            r_stv       <= '0;
            r_cnt       <= '0;
            r_dv        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rec_size <= i_cfg_wdata;
                r_slots_ok <= 1'b0;
            end
            if (st_we) begin
                r_stv[r_blk] <= 1'b1;
            end
            if (r_state == S_OUT && out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_INIT, S_AINIT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[WIDX_W-1:0] == WIDX_W'(MAP_WORDS - 1)) begin
                        r_state <= (r_state == S_INIT) ? S_IDLE : S_ADDR;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= t_op'(i_opcode);
                        r_addr  <= i_free_address;
                        r_blk   <= (t_op'(i_opcode) == OP_ALLOC) ? r_cur
                                   : i_free_address[ADDR_W-1:SIZE_W];
                        r_gaddr <= '0;
                        r_slot  <= '0;
                        r_err   <= ERR_OK;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_state <= r_slots_ok ? S_BR : S_DIVR;
                end
                S_DIVR: begin
                    if (div_done) begin
                        r_slots    <= (div_quo > SIZE_W'(SLOT_MAX)) ? SLOT_MAX
                                      : div_quo[CNT_W-1:0];
                        r_slots_ok <= 1'b1;
                        r_state    <= S_BR;
                    end
                end
                S_BR: begin
                    r_st    <= st_cur;
                    r_cnt   <= '0;
                    r_dv    <= 1'b0;
                    r_found <= 1'b0;
                    r_more  <= 1'b0;
                    if (r_op == OP_ALLOC) begin
                        if (r_exh) begin
                            r_err   <= ERR_EXHAUSTED;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_ASCAN;
                        end
                    end else if (free_ok) begin
                        r_state <= S_FDIV;
                    end else begin
                        r_err   <= ERR_BAD_FREE;
                        r_blk   <= '0;
                        r_st    <= ST_RESERVED;
                        r_state <= S_OUT;
                    end
                end
                S_ASCAN, S_FSCAN: begin
                    if (!r_cnt[WIDX_W]) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_dw  <= r_cnt[WIDX_W-1:0];
                    end
                    r_dv <= !r_cnt[WIDX_W];
                    if (r_dv) begin
                        if (r_state == S_FSCAN) begin
                            if (sc_used != '0) begin
                                r_more <= 1'b1;
                            end
                        end else if (!r_found && sc_free != '0) begin
                            // first free slot: claim it, note whether another remains
                            r_found <= 1'b1;
                            r_wi    <= r_dw;
                            r_word  <= map_rdata | (WORD_W'(1) << sc_bit);
                            r_slot  <= {r_dw, sc_bit};
                            if ((sc_free & (sc_free - WORD_W'(1))) != '0) begin
                                r_more <= 1'b1;
                            end
                        end else if (sc_free != '0) begin
                            r_more <= 1'b1;
                        end
                        if (r_dw == WIDX_W'(MAP_WORDS - 1)) begin
                            r_state <= (r_state == S_FSCAN) ? S_FEND : S_AEND;
                        end
                    end
                end
                S_AEND: begin
                    r_cnt <= '0;
                    if (!r_found) begin
                        r_err   <= ERR_EXHAUSTED;
                        r_slot  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_st   <= alloc_st;
                        r_prod <= PROD_W'(r_slot * eff);
                        if (r_more) begin
                            r_state <= S_ADDR;
                        end else if (r_cur == LAST_BLK) begin
                            r_exh   <= 1'b1;
                            r_state <= S_ADDR;
                        end else begin
                            // advance to the next block and lay out its bitmap
                            r_cur   <= r_cur + 1'b1;
                            r_state <= S_AINIT;
                        end
                    end
                end
                S_ADDR: begin
                    r_gaddr <= {r_blk, SIZE_W'(0)} + ADDR_W'(HDR_BYTES)
                             + r_prod[ADDR_W-1:0];
                    r_state <= S_OUT;
                end
                S_FDIV: begin
                    if (div_done) begin
                        if (div_rem != '0 || div_quo >= SIZE_W'(r_slots)) begin
                            r_err   <= ERR_BAD_FREE;
                            r_blk   <= '0;
                            r_st    <= ST_RESERVED;
                            r_state <= S_OUT;
                        end else begin
                            r_slot  <= div_quo[SLOT_W-1:0];
                            r_state <= S_FRD0;
                        end
                    end
                end
                S_FRD0: begin
                    r_state <= S_FRD1;
                end
                S_FRD1: begin
                    r_word  <= map_rdata & ~(WORD_W'(1) << r_slot[5:0]);
                    r_state <= S_FWR;
                end
                S_FWR: begin
                    r_cnt   <= '0;
                    r_dv    <= 1'b0;
                    r_more  <= 1'b0;
                    r_state <= S_FSCAN;
                end
                S_FEND: begin
                    if (!r_more) begin
                        r_st <= ST_UNUSED;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output word, held while stalled
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_load) begin
            o_granted_address <= r_gaddr;
            o_slot_index      <= r_slot;
            o_block_number    <= r_blk;
            o_block_state     <= r_st;
            o_error_code      <= r_err;
        end
    end

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_error_code != 2'd3)
        else $error("undefined error code on output");

    a_exh_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exh |=> r_exh)
        else $error("exhaustion flag cleared");

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur >= FIRST_BLK)
        else $error("current block below first data block");

    a_grant_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code == ERR_OK && o_granted_address != '0)
        |-> (o_block_state == ST_PARTIAL || o_block_state == ST_FULL))
        else $error("granted record in a block not partial or full");

endmodule
